// File: hdl/crom_pkg.sv
// Shared types and constants of the cross reach outline marker.
package crom_pkg;

	localparam int PIX_W      = 8;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 12;
	localparam int DIM_W      = 13;
	localparam int OUT_COL_W  = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam int QUEUE_DEPTH = 4;
	localparam int RES_DEPTH   = 4;
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_VALUE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_VALUE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_VALUE = 3'd5;

	typedef struct packed {
		logic [COL_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [PIX_W-1:0] black_value;
		logic [PIX_W-1:0] white_value;
		logic [PIX_W-1:0] fill_value;
		logic [PIX_W-1:0] outline_value;
	} cfg_t;

	// one classified pixel, front to back
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] px;
		logic             has_up;
		logic             has_lo;
		logic             right_ok;
		logic             up_clamp;
	} entry_t;

	// results caused by one pixel
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row_up;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] pix_up;
		logic [PIX_W-1:0] pix_lo;
		logic             has_up;
		logic             has_lo;
	} pair_t;

	typedef enum logic {
		PH_READ_A,
		PH_READ_B
	} back_phase_t;

endpackage

// File: hdl/crom_fifo.sv
// Small register FIFO used between the stages.
module crom_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = store_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;

endmodule

// File: hdl/crom_front.sv
// Front end: accepts pixels, tracks raster position and classifies each word.
module crom_front #(
	parameter int REACH     = 10,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  crom_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [crom_pkg::PIX_W-1:0]   pixel_in,
	input  logic                         q_full,
	output logic                         q_push,
	output crom_pkg::entry_t             q_entry
);
	import crom_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             pre_wrap;
	logic [DIM_W-1:0] row_t;
	logic [COL_W-1:0] col_a;
	logic [ROW_W-1:0] row_a;
	logic [DIM_W-1:0] col_n;
	logic [DIM_W-1:0] row_n;
	logic [COL_W-1:0] col_next;
	logic [ROW_W-1:0] row_next;

	always_comb begin
		if (cfg.image_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(cfg.image_width) > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(cfg.image_width);
		end
		if (cfg.image_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (cfg.image_height > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.image_height;
		end
	end

	// position of this word, after a possible size change
	always_comb begin
		pre_wrap = (DIM_W'(col_q) >= w_eff);
		row_t    = DIM_W'(row_q) + DIM_W'(pre_wrap);
		col_a    = pre_wrap ? '0 : col_q;
		row_a    = (row_t >= h_eff) ? '0 : row_t[ROW_W-1:0];
	end

	// position of the following word
	always_comb begin
		col_n    = DIM_W'(col_a) + 1'b1;
		row_n    = DIM_W'(row_a);
		col_next = col_n[COL_W-1:0];
		if (col_n >= w_eff) begin
			col_next = '0;
			row_n    = DIM_W'(row_a) + 1'b1;
		end
		row_next = (row_n >= h_eff) ? '0 : row_n[ROW_W-1:0];
	end

	always_comb begin
		q_entry.col      = col_a;
		q_entry.row      = row_a;
		q_entry.px       = pixel_in;
		q_entry.has_up   = (DIM_W'(row_a) >= DIM_W'(REACH));
		q_entry.has_lo   = (DIM_W'(row_a) + DIM_W'(REACH) >= h_eff);
		q_entry.right_ok = (DIM_W'(col_a) + DIM_W'(REACH) < w_eff);
		q_entry.up_clamp = (DIM_W'(row_a) < DIM_W'(2 * REACH));
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

// File: hdl/crom_back.sv
// Back end: ring row memory, neighbor reads and outline decision.
module crom_back #(
	parameter int REACH     = 10,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  crom_pkg::cfg_t                   cfg,
	input  logic                             q_valid,
	input  crom_pkg::entry_t                 q_entry,
	output logic                             q_pop,
	input  logic [crom_pkg::RES_CNT_W-1:0]   res_count,
	output logic                             res_push,
	output crom_pkg::pair_t                  res_pair
);
	import crom_pkg::*;

	localparam int RING_ROWS = 2 * REACH;
	localparam int SLOT_W    = $clog2(RING_ROWS);
	localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int XW        = COL_W + 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RING_ROWS - 1);
	localparam logic [SLOT_W-1:0] SLOT_REACH = SLOT_W'(REACH);
	localparam logic [XW-1:0]     COL_LAST   = XW'(MAX_WIDTH - 1);

	function automatic logic [AW-1:0] addr_of(logic [SLOT_W-1:0] s, logic [XW-1:0] c);
		return AW'(s * MAX_WIDTH + c);
	endfunction

	back_phase_t       phase_q;
	back_phase_t       phase_d;
	logic              go;
	logic              we;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_d;
	logic [ROW_W-1:0]  prev_row_q;
	entry_t            cur_s1;
	logic [SLOT_W-1:0] slot_s1;
	entry_t            cur_s2;
	logic              valid_s2;
	logic [PIX_W-1:0]  v_s2;
	logic [PIX_W-1:0]  up_s2;

	entry_t            sel;
	logic [SLOT_W-1:0] sel_slot;
	logic [SLOT_W-1:0] slot_y;
	logic [SLOT_W-1:0] slot_up;
	logic [XW-1:0]     col_x;
	logic [XW-1:0]     col_l;
	logic [XW-1:0]     col_r_sum;
	logic [XW-1:0]     col_r;
	logic [AW-1:0]     ra0;
	logic [AW-1:0]     ra1;
	logic [AW-1:0]     wa;

	logic [PIX_W-1:0]  ring_mem [MEM_DEPTH];
	logic [PIX_W-1:0]  rd0_q;
	logic [PIX_W-1:0]  rd1_q;

	logic              hit;
	logic [PIX_W-1:0]  p_up;
	logic [PIX_W-1:0]  p_lo;

	// ring slot of the head word: rows only step by one or restart at zero
	always_comb begin
		if (q_entry.row == '0) begin
			slot_d = '0;
		end else if (q_entry.row != prev_row_q) begin
			slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
		end else begin
			slot_d = slot_q;
		end
	end

	assign go = q_valid && (res_count <= RES_CNT_W'(RES_DEPTH - 2));

	always_comb begin
		case (phase_q)
			PH_READ_A: phase_d = go ? PH_READ_B : PH_READ_A;
			PH_READ_B: phase_d = PH_READ_A;
			default:   phase_d = PH_READ_A;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		we    = 1'b0;
		case (phase_q)
			PH_READ_A: q_pop = go;
			PH_READ_B: we = 1'b1;
			default: begin
				q_pop = 1'b0;
				we    = 1'b0;
			end
		endcase
	end

	// addresses: center and above in the first pass, left and right in the second
	always_comb begin
		sel       = (phase_q == PH_READ_A) ? q_entry : cur_s1;
		sel_slot  = (phase_q == PH_READ_A) ? slot_d : slot_s1;
		slot_y    = (sel_slot >= SLOT_REACH) ? sel_slot - SLOT_REACH : sel_slot + SLOT_REACH;
		slot_up   = sel.up_clamp ? '0 : sel_slot;
		col_x     = XW'(sel.col);
		col_l     = (col_x >= XW'(REACH)) ? col_x - XW'(REACH) : '0;
		col_r_sum = col_x + XW'(REACH);
		col_r     = (col_r_sum > COL_LAST) ? COL_LAST : col_r_sum;
		if (phase_q == PH_READ_A) begin
			ra0 = addr_of(slot_y, col_x);
			ra1 = addr_of(slot_up, col_x);
		end else begin
			ra0 = addr_of(slot_y, col_l);
			ra1 = addr_of(slot_y, col_r);
		end
		wa = addr_of(slot_s1, XW'(cur_s1.col));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ring_mem[wa] <= cur_s1.px;
		end
		rd0_q <= ring_mem[ra0];
		rd1_q <= ring_mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_READ_A;
			slot_q     <= '0;
			prev_row_q <= '0;
			valid_s2   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			valid_s2 <= (phase_q == PH_READ_B);
			if (q_pop) begin
				slot_q     <= slot_d;
				prev_row_q <= q_entry.row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_s1  <= q_entry;
			slot_s1 <= slot_d;
		end
		if (phase_q == PH_READ_B) begin
			cur_s2 <= cur_s1;
			v_s2   <= rd0_q;
			up_s2  <= rd1_q;
		end
	end

	// rd0_q / rd1_q hold left / right here
	always_comb begin
		hit = (v_s2 == cfg.black_value) && cur_s2.right_ok &&
			((up_s2 == cfg.fill_value) || (cur_s2.px == cfg.fill_value) ||
			(rd0_q == cfg.fill_value) || (rd1_q == cfg.fill_value));
		p_up = hit ? cfg.outline_value : v_s2;
		if (p_up != cfg.fill_value && p_up != cfg.outline_value) begin
			p_up = cfg.white_value;
		end
		p_lo = cur_s2.px;
		if (p_lo != cfg.fill_value && p_lo != cfg.outline_value) begin
			p_lo = cfg.white_value;
		end
	end

	always_comb begin
		res_pair.col    = cur_s2.col;
		res_pair.row_up = cur_s2.row - ROW_W'(REACH);
		res_pair.row    = cur_s2.row;
		res_pair.pix_up = p_up;
		res_pair.pix_lo = p_lo;
		res_pair.has_up = cur_s2.has_up;
		res_pair.has_lo = cur_s2.has_lo;
	end

	assign res_push = valid_s2 && (cur_s2.has_up || cur_s2.has_lo);

endmodule

// File: hdl/crom_out.sv
// Output stage: result queue and serializer for up to two words per pixel.
module crom_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_push,
	input  crom_pkg::pair_t                    res_pair,
	output logic [crom_pkg::RES_CNT_W-1:0]     res_count,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [crom_pkg::OUT_COL_W-1:0]     out_column,
	output logic [crom_pkg::ROW_W-1:0]         out_row,
	output logic [crom_pkg::PIX_W-1:0]         out_pixel,
	output logic                               last_of_run
);
	import crom_pkg::*;

	pair_t head;
	logic  empty;
	logic  pop;
	logic  show_up;
	logic  sent_up_q;
	logic  take;

	crom_fifo #(
		.WIDTH($bits(pair_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res_pair),
		.pop    (pop),
		.rd_data(head),
		.empty  (empty),
		.full   (),
		.count  (res_count)
	);

	assign show_up     = head.has_up && !sent_up_q;
	assign out_valid   = !empty;
	assign out_column  = OUT_COL_W'(head.col);
	assign out_row     = show_up ? head.row_up : head.row;
	assign out_pixel   = show_up ? head.pix_up : head.pix_lo;
	assign last_of_run = show_up ? !head.has_lo : 1'b1;
	assign take        = out_valid && out_ready;
	assign pop         = take && !(show_up && head.has_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_up_q <= 1'b0;
		end else if (take) begin
			sent_up_q <= !pop;
		end
	end

endmodule

// File: hdl/cross_reach_outline_marker.sv
// Top level: configuration registers, front end, queue, back end and output stage.
// Each pixel takes two passes over the two read ports of the ring row memory
// (center and above, then left and right). A new pixel is taken after the second pass
// while the last one finishes, and none while the result queue is nearly full.
// Reset: position counters cleared, registers to their defaults, queues emptied;
// the ring row memory is not cleared and needs no clearing pass.
module cross_reach_outline_marker #(
	parameter int REACH     = 10,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [crom_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crom_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [crom_pkg::PIX_W-1:0]           pixel_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [crom_pkg::OUT_COL_W-1:0]       out_column,
	output logic [crom_pkg::ROW_W-1:0]           out_row,
	output logic [crom_pkg::PIX_W-1:0]           out_pixel,
	output logic                                 last_of_run
);
	import crom_pkg::*;

	cfg_t                 cfg_q;
	logic                 q_push;
	entry_t               q_wr;
	logic                 q_pop;
	entry_t               q_head;
	logic                 q_empty;
	logic                 q_full;
	logic                 res_push;
	pair_t                res_pair;
	logic [RES_CNT_W-1:0] res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= COL_W'(1024);
			cfg_q.image_height  <= DIM_W'(1024);
			cfg_q.black_value   <= 8'd0;
			cfg_q.white_value   <= 8'd255;
			cfg_q.fill_value    <= 8'd128;
			cfg_q.outline_value <= 8'd64;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[COL_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[DIM_W-1:0];
				REG_BLACK_VALUE:   cfg_q.black_value   <= cfg_data[PIX_W-1:0];
				REG_WHITE_VALUE:   cfg_q.white_value   <= cfg_data[PIX_W-1:0];
				REG_FILL_VALUE:    cfg_q.fill_value    <= cfg_data[PIX_W-1:0];
				REG_OUTLINE_VALUE: cfg_q.outline_value <= cfg_data[PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	crom_front #(
		.REACH    (REACH),
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_in(pixel_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_wr)
	);

	crom_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr),
		.pop    (q_pop),
		.rd_data(q_head),
		.empty  (q_empty),
		.full   (q_full),
		.count  ()
	);

	crom_back #(
		.REACH    (REACH),
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (!q_empty),
		.q_entry  (q_head),
		.q_pop    (q_pop),
		.res_count(res_count),
		.res_push (res_push),
		.res_pair (res_pair)
	);

	crom_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_push   (res_push),
		.res_pair   (res_pair),
		.res_count  (res_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_column (out_column),
		.out_row    (out_row),
		.out_pixel  (out_pixel),
		.last_of_run(last_of_run)
	);

endmodule
